FILE: hw/rtl/sdsp_pkg.sv
// Shared types and constants of the sound DSP port interface.
// No dependencies; the reply queue, the top level and the bench import this package.
package sdsp_pkg;

  // Reply queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFW = $clog2(QUEUE_DEPTH + 1);

  // Access kinds
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Port offsets
  localparam logic [3:0] PORT_MIX_INDEX = 4'h4;
  localparam logic [3:0] PORT_MIX_DATA  = 4'h5;
  localparam logic [3:0] PORT_RESET     = 4'h6;
  localparam logic [3:0] PORT_READ_DATA = 4'hA;
  localparam logic [3:0] PORT_COMMAND   = 4'hC;
  localparam logic [3:0] PORT_STATUS    = 4'hE;

  // DSP command bytes
  localparam logic [7:0] DSP_CMD_STOP    = 8'hD0;
  localparam logic [7:0] DSP_CMD_START   = 8'hD4;
  localparam logic [7:0] DSP_CMD_LENGTH  = 8'h14;
  localparam logic [7:0] DSP_CMD_RATE    = 8'h40;
  localparam logic [7:0] DSP_CMD_VERSION = 8'hE1;

  // Reply bytes and mixer constants
  localparam logic [7:0] REPLY_RESET     = 8'hAA;
  localparam logic [7:0] VERSION_MAJOR   = 8'h01;
  localparam logic [7:0] VERSION_MINOR   = 8'h05;
  localparam logic [7:0] STATUS_READY    = 8'h80;
  localparam logic [7:0] MIX_REG_STEREO  = 8'h0E;

  // Command byte that the next command-port write completes
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RATE = 2'd1,
    PEND_LEN  = 2'd2
  } pend_t;

  // Control from the decoder to the reply queue
  typedef struct packed {
    logic       clear;
    logic       push_a;
    logic [7:0] data_a;
    logic       push_b;
    logic [7:0] data_b;
    logic       pop;
  } q_ctrl_t;

  // Circular pointer increment
  function automatic logic [QPW-1:0] ptr_inc(input logic [QPW-1:0] ptr);
    ptr_inc = (ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/sdsp_if.sv
// Valid/ready channel interfaces for port accesses and their results.
// Depends on nothing but the payload widths fixed by the block.
interface sdsp_req_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] port;
  logic [7:0] wdata;

  modport source (input clk, output valid, input ready, output cmd, port, wdata);
  modport sink   (input clk, input valid, output ready, input cmd, port, wdata);
endinterface

interface sdsp_rsp_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [7:0]  rdata;
  logic        dma_start;
  logic        dma_stop;
  logic [15:0] dma_length;
  logic [7:0]  rate_code;
  logic        stereo_mode;

  modport source (input clk, output valid, input ready,
                  output rdata, dma_start, dma_stop, dma_length, rate_code, stereo_mode);
  modport sink   (input clk, input valid, output ready,
                  input rdata, dma_start, dma_stop, dma_length, rate_code, stereo_mode);
endinterface

FILE: hw/rtl/sdsp_reply_queue.sv
// Reply byte queue of the DSP: clear, up to two pushes and one pop per cycle.
// Depends on sdsp_pkg.
module sdsp_reply_queue
  import sdsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_ctrl_t    ctrl,
  output logic [7:0] head_data,
  output logic       not_empty
);

  logic [7:0]     mem [QUEUE_DEPTH];
  logic [QPW-1:0] head, tail;
  logic [QFW-1:0] fill;
  logic [QPW-1:0] head_next, tail_next;
  logic [QFW-1:0] fill_next;
  logic           we_a, we_b;
  logic [QPW-1:0] addr_a, addr_b;

  // Pointer update; pushes beyond the depth are dropped
  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    we_a      = 1'b0;
    we_b      = 1'b0;
    addr_a    = tail;
    addr_b    = tail;
    if (ctrl.clear) begin
      head_next = '0;
      tail_next = '0;
      fill_next = '0;
    end
    if (ctrl.push_a && fill_next != QFW'(QUEUE_DEPTH)) begin
      we_a      = 1'b1;
      addr_a    = tail_next;
      tail_next = ptr_inc(tail_next);
      fill_next = fill_next + 1'b1;
    end
    if (ctrl.push_b && fill_next != QFW'(QUEUE_DEPTH)) begin
      we_b      = 1'b1;
      addr_b    = tail_next;
      tail_next = ptr_inc(tail_next);
      fill_next = fill_next + 1'b1;
    end
    if (ctrl.pop && fill_next != '0) begin
      head_next = ptr_inc(head_next);
      fill_next = fill_next - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk) begin
    if (we_a) mem[addr_a] <= ctrl.data_a;
    if (we_b) mem[addr_b] <= ctrl.data_b;
  end

  assign head_data = mem[head];
  assign not_empty = (fill != '0);

endmodule

FILE: hw/rtl/sound_dsp_port_interface.sv
// Top level of the sound DSP port interface: access register, decoder, result register.
// Depends on sdsp_pkg, sdsp_if and sdsp_reply_queue.
//
// One port access (read or write at a 4-bit offset) per transfer on req, one result per
// transfer on rsp. The block takes a new access every cycle unless rsp backpressure holds
// it. An access taken sits in the access register; when it advances, its result moves into
// the result register, from which it is offered on rsp. The whole decode and the reply
// queue update sit between those two registers, so each access sees all state left by
// the one before it.
// Backpressure on rsp holds both registers; req keeps flowing while the result register
// is free or being drained.
module sound_dsp_port_interface
  import sdsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sdsp_req_if.sink    req,
  sdsp_rsp_if.source  rsp
);

  // Access register
  logic       s1_valid;
  logic       s1_cmd;
  logic [3:0] s1_port;
  logic [7:0] s1_wdata;
  logic       advance;

  // Device state
  pend_t       pending, pending_next;
  logic        length_phase, length_phase_next;
  logic [15:0] transfer_length, transfer_length_next;
  logic [7:0]  rate_byte, rate_byte_next;
  logic        stereo_bit, stereo_bit_next;
  logic [7:0]  mixer_select, mixer_select_next;

  // Decode results
  logic [7:0] rdata_next;
  logic       start_next, stop_next;
  q_ctrl_t    qctrl, qctrl_gated;
  logic [7:0] q_head;
  logic       q_not_empty;

  // Result register
  logic        out_valid;
  logic [7:0]  out_rdata;
  logic        out_start, out_stop;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_cmd   <= req.cmd;
      s1_port  <= req.port;
      s1_wdata <= req.wdata;
    end
  end

  // Access decode
  always_comb begin
    pending_next         = pending;
    length_phase_next    = length_phase;
    transfer_length_next = transfer_length;
    rate_byte_next       = rate_byte;
    stereo_bit_next      = stereo_bit;
    mixer_select_next    = mixer_select;
    rdata_next           = '0;
    start_next           = 1'b0;
    stop_next            = 1'b0;
    qctrl                = '0;
    qctrl.data_a         = REPLY_RESET;
    qctrl.data_b         = VERSION_MINOR;
    if (s1_cmd == CMD_READ) begin
      unique case (s1_port)
        PORT_READ_DATA: begin
          qctrl.pop  = 1'b1;
          rdata_next = q_not_empty ? q_head : '0;
        end
        PORT_COMMAND, PORT_STATUS: begin
          rdata_next = q_not_empty ? STATUS_READY : '0;
        end
        PORT_MIX_DATA: begin
          rdata_next = (mixer_select == MIX_REG_STEREO) ? {6'b0, stereo_bit, 1'b0} : '0;
        end
        default: ;
      endcase
    end else begin
      unique case (s1_port)
        PORT_RESET: begin
          qctrl.clear  = 1'b1;
          qctrl.push_a = 1'b1;
          qctrl.data_a = REPLY_RESET;
        end
        PORT_COMMAND: begin
          unique case (pending)
            PEND_RATE: begin
              rate_byte_next = s1_wdata;
              pending_next   = PEND_NONE;
            end
            PEND_LEN: begin
              length_phase_next = !length_phase;
              if (!length_phase) begin
                transfer_length_next = {8'h00, s1_wdata};
              end else begin
                transfer_length_next = transfer_length + {s1_wdata, 8'h00};
                pending_next         = PEND_NONE;
                start_next           = 1'b1;
              end
            end
            default: begin
              unique case (s1_wdata)
                DSP_CMD_STOP:   stop_next = 1'b1;
                DSP_CMD_START:  start_next = 1'b1;
                DSP_CMD_LENGTH: begin
                  length_phase_next = 1'b0;
                  pending_next      = PEND_LEN;
                end
                DSP_CMD_RATE:   pending_next = PEND_RATE;
                DSP_CMD_VERSION: begin
                  qctrl.push_a = 1'b1;
                  qctrl.data_a = VERSION_MAJOR;
                  qctrl.push_b = 1'b1;
                  qctrl.data_b = VERSION_MINOR;
                end
                default: ;
              endcase
            end
          endcase
        end
        PORT_MIX_INDEX: mixer_select_next = s1_wdata;
        PORT_MIX_DATA: begin
          if (mixer_select == MIX_REG_STEREO) stereo_bit_next = s1_wdata[1];
        end
        default: ;
      endcase
    end
  end

  // Queue acts only when the access moves on
  always_comb begin
    qctrl_gated        = qctrl;
    qctrl_gated.clear  = qctrl.clear && advance;
    qctrl_gated.push_a = qctrl.push_a && advance;
    qctrl_gated.push_b = qctrl.push_b && advance;
    qctrl_gated.pop    = qctrl.pop && advance;
  end

  sdsp_reply_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (qctrl_gated),
    .head_data (q_head),
    .not_empty (q_not_empty)
  );

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending         <= PEND_NONE;
      length_phase    <= 1'b0;
      transfer_length <= '0;
      rate_byte       <= '0;
      stereo_bit      <= 1'b0;
      mixer_select    <= '0;
    end else if (advance) begin
      pending         <= pending_next;
      length_phase    <= length_phase_next;
      transfer_length <= transfer_length_next;
      rate_byte       <= rate_byte_next;
      stereo_bit      <= stereo_bit_next;
      mixer_select    <= mixer_select_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rdata <= rdata_next;
      out_start <= start_next;
      out_stop  <= stop_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.rdata       = out_rdata;
  assign rsp.dma_start   = out_start;
  assign rsp.dma_stop    = out_stop;
  // Persistent fields already hold the value left by the access in the result register
  assign rsp.dma_length  = transfer_length;
  assign rsp.rate_code   = rate_byte;
  assign rsp.stereo_mode = stereo_bit;

endmodule

FILE: hw/rtl/sdsp_checker.sv
// Port-level checks of the sound DSP port interface, bound to its top level.
// Depends on sound_dsp_port_interface and the channel interfaces.
module sdsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_rdata,
  input logic       rsp_dma_start,
  input logic       rsp_dma_stop
);

  // Accesses taken whose result has not been transferred yet
  logic [1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 2'((req_valid && req_ready) ? 1 : 0)
                           - 2'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> inflight != 2'd0)
    else $error("result shown with no access taken");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    inflight <= 2'd2)
    else $error("more accesses in flight than registers");

  a_dma_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_dma_start || rsp_dma_stop) |->
      !(rsp_dma_start && rsp_dma_stop) && rsp_rdata == 8'h00)
    else $error("DMA pulse on a read or both pulses at once");

endmodule

bind sound_dsp_port_interface sdsp_checker u_sdsp_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_rdata     (rsp.rdata),
  .rsp_dma_start (rsp.dma_start),
  .rsp_dma_stop  (rsp.dma_stop)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the sound DSP port interface: drives port accesses, predicts
// each result and checks it field by field. Depends on sdsp_pkg, sdsp_if and the RTL.
module tb_top;
  import sdsp_pkg::*;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        dma_start;
    logic        dma_stop;
    logic [15:0] dma_length;
    logic [7:0]  rate_code;
    logic        stereo_mode;
  } dsp_result_t;

  // Predicts the result of every accepted access and checks results in order
  class dsp_scoreboard;
    logic [7:0]  reply_bytes[$];
    dsp_result_t port_results[$];
    pend_t       pend;
    logic        len_phase;
    logic [15:0] xfer_len;
    logic [7:0]  rate;
    logic        stereo;
    logic [7:0]  mix_sel;
    int          errors;

    function new();
      pend      = PEND_NONE;
      len_phase = 1'b0;
      xfer_len  = '0;
      rate      = '0;
      stereo    = 1'b0;
      mix_sel   = '0;
      errors    = 0;
    endfunction

    // Bytes beyond the queue depth are dropped
    function void push_reply(logic [7:0] b);
      if (reply_bytes.size() < QUEUE_DEPTH) reply_bytes.push_back(b);
    endfunction

    function void note_access(logic kind, logic [3:0] p, logic [7:0] d);
      dsp_result_t r;
      r = '0;
      if (kind == CMD_READ) begin
        case (p)
          PORT_READ_DATA: if (reply_bytes.size() != 0) r.rdata = reply_bytes.pop_front();
          PORT_COMMAND, PORT_STATUS: r.rdata = (reply_bytes.size() != 0) ? STATUS_READY : 8'h00;
          PORT_MIX_DATA: r.rdata = (mix_sel == MIX_REG_STEREO) ? {6'b0, stereo, 1'b0} : 8'h00;
          default: ;
        endcase
      end else begin
        case (p)
          PORT_RESET: begin
            reply_bytes.delete();
            push_reply(REPLY_RESET);
          end
          PORT_COMMAND: begin
            if (pend == PEND_RATE) begin
              rate = d;
              pend = PEND_NONE;
            end else if (pend == PEND_LEN) begin
              // low byte first, then high byte completes the length and starts DMA
              len_phase = ~len_phase;
              if (len_phase) begin
                xfer_len = {8'h00, d};
              end else begin
                xfer_len = xfer_len + {d, 8'h00};
                pend = PEND_NONE;
                r.dma_start = 1'b1;
              end
            end else begin
              case (d)
                DSP_CMD_STOP:  r.dma_stop = 1'b1;
                DSP_CMD_START: r.dma_start = 1'b1;
                DSP_CMD_LENGTH: begin
                  len_phase = 1'b0;
                  pend = PEND_LEN;
                end
                DSP_CMD_RATE: pend = PEND_RATE;
                DSP_CMD_VERSION: begin
                  push_reply(VERSION_MAJOR);
                  push_reply(VERSION_MINOR);
                end
                default: ;
              endcase
            end
          end
          PORT_MIX_INDEX: mix_sel = d;
          PORT_MIX_DATA: if (mix_sel == MIX_REG_STEREO) stereo = d[1];
          default: ;
        endcase
      end
      r.dma_length  = xfer_len;
      r.rate_code   = rate;
      r.stereo_mode = stereo;
      port_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dsp_result_t got);
      dsp_result_t want;
      if (port_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = port_results.pop_front();
      compare_field("rdata", 16'(want.rdata), 16'(got.rdata));
      compare_field("dma_start", 16'(want.dma_start), 16'(got.dma_start));
      compare_field("dma_stop", 16'(want.dma_stop), 16'(got.dma_stop));
      compare_field("dma_length", want.dma_length, got.dma_length);
      compare_field("rate_code", 16'(want.rate_code), 16'(got.rate_code));
      compare_field("stereo_mode", 16'(want.stereo_mode), 16'(got.stereo_mode));
    endfunction

    function int outstanding();
      return port_results.size();
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdsp_req_if req_bus (.clk(clk));
  sdsp_rsp_if rsp_bus (.clk(clk));

  sound_dsp_port_interface uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  dsp_scoreboard board;
  dsp_result_t   seen;
  int            tx_idle_pct = 7;
  int            rx_idle_pct = 45;
  int            hold_request = 0;
  int            sent = 0;
  int            cycles = 0;

  always #4 clk = ~clk;

  // Transfer monitors: both sample pre-edge values
  always @(posedge clk) begin
    if (!rst && req_bus.valid && req_bus.ready)
      board.note_access(req_bus.cmd, req_bus.port, req_bus.wdata);
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      seen.rdata       = rsp_bus.rdata;
      seen.dma_start   = rsp_bus.dma_start;
      seen.dma_stop    = rsp_bus.dma_stop;
      seen.dma_length  = rsp_bus.dma_length;
      seen.rate_code   = rsp_bus.rate_code;
      seen.stereo_mode = rsp_bus.stereo_mode;
      board.check_result(seen);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side: random stalls plus an occasional long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        stall_left   = 120;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // One access; returns right after the edge that takes it
  task automatic send_access(input logic kind, input logic [3:0] p, input logic [7:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd   <= kind;
    req_bus.port  <= p;
    req_bus.wdata <= d;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic run_directed();
    send_access(CMD_READ, PORT_READ_DATA, 8'hFF);   // empty queue read
    send_access(CMD_READ, PORT_COMMAND, 8'h00);
    send_access(CMD_WRITE, PORT_RESET, 8'h00);
    send_access(CMD_READ, PORT_STATUS, 8'h00);
    send_access(CMD_READ, PORT_READ_DATA, 8'h00);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_VERSION);
    send_access(CMD_READ, PORT_READ_DATA, 8'h00);
    send_access(CMD_READ, PORT_READ_DATA, 8'h00);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_RATE);
    send_access(CMD_WRITE, PORT_COMMAND, 8'hFF);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_RATE);
    send_access(CMD_WRITE, PORT_COMMAND, 8'h00);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_LENGTH);
    send_access(CMD_WRITE, PORT_COMMAND, 8'hFF);
    send_access(CMD_WRITE, PORT_COMMAND, 8'hFF);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_START);
    send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_STOP);
    send_access(CMD_WRITE, PORT_COMMAND, 8'hD1);     // unknown command
    send_access(CMD_WRITE, PORT_MIX_INDEX, MIX_REG_STEREO);
    send_access(CMD_WRITE, PORT_MIX_DATA, 8'hFF);
    send_access(CMD_READ, PORT_MIX_DATA, 8'h00);
    send_access(CMD_WRITE, PORT_MIX_INDEX, 8'h00);
    send_access(CMD_WRITE, PORT_MIX_DATA, 8'h00);    // ignored, wrong mixer register
    send_access(CMD_READ, PORT_MIX_DATA, 8'h00);
    send_access(CMD_WRITE, 4'hF, 8'hFF);             // unknown port write
    send_access(CMD_READ, 4'h0, 8'h00);              // unknown port read
  endtask

  // Mostly well-formed command sequences with random content, some noise
  task automatic run_random(input int n_items);
    int stop_at;
    int pick;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_RATE);
        send_access(CMD_WRITE, PORT_COMMAND, 8'($urandom_range(255)));
      end else if (pick < 24) begin
        send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_LENGTH);
        send_access(CMD_WRITE, PORT_COMMAND, 8'($urandom_range(255)));
        send_access(CMD_WRITE, PORT_COMMAND, 8'($urandom_range(255)));
      end else if (pick < 34) begin
        repeat ($urandom_range(1, 9)) send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_VERSION);
      end else if (pick < 42) begin
        send_access(CMD_WRITE, PORT_RESET, 8'($urandom_range(255)));
      end else if (pick < 58) begin
        repeat ($urandom_range(1, 6))
          send_access(CMD_READ, PORT_READ_DATA, 8'($urandom_range(255)));
      end else if (pick < 66) begin
        send_access(CMD_READ, $urandom_range(1) ? PORT_COMMAND : PORT_STATUS,
                    8'($urandom_range(255)));
      end else if (pick < 76) begin
        send_access(CMD_WRITE, PORT_MIX_INDEX,
                    $urandom_range(1) ? MIX_REG_STEREO : 8'($urandom_range(255)));
        send_access(CMD_WRITE, PORT_MIX_DATA, 8'($urandom_range(255)));
        send_access(CMD_READ, PORT_MIX_DATA, 8'($urandom_range(255)));
      end else if (pick < 84) begin
        case ($urandom_range(3))
          0: send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_START);
          1: send_access(CMD_WRITE, PORT_COMMAND, DSP_CMD_STOP);
          2: send_access(CMD_WRITE, PORT_COMMAND, $urandom_range(1) ? 8'hD1 : 8'hD3);
          default: send_access(CMD_WRITE, PORT_COMMAND, 8'($urandom_range(255)));
        endcase
      end else begin
        repeat ($urandom_range(1, 3))
          send_access(1'($urandom_range(1)), 4'($urandom_range(15)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Main sequence
  initial begin
    board = new();
    req_bus.valid <= 1'b0;
    req_bus.cmd   <= CMD_WRITE;
    req_bus.port  <= '0;
    req_bus.wdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 7;
    rx_idle_pct = 45;
    run_directed();
    hold_request = 1;
    run_random(350);

    tx_idle_pct = 45;
    rx_idle_pct = 7;
    run_random(360);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1;
    run_random(360);
    req_bus.valid <= 1'b0;
    // let the monitor note the last transfer before draining
    @(posedge clk);

    while (board.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sdsp_pkg.sv
hw/rtl/sdsp_if.sv
hw/rtl/sdsp_reply_queue.sv
hw/rtl/sound_dsp_port_interface.sv
hw/rtl/sdsp_checker.sv
tb/tb_top.sv
